### rtl/core/rvc_pkg.sv
// Shared types, constants and instruction decode for the RV32 subset core.
// No dependencies; imported by the core top level and its checker.
package rvc_pkg;

    localparam int XLEN      = 32;
    localparam int REG_AW    = 5;
    localparam int REG_WORDS = 1 << REG_AW;

    // Word count of main memory; keep a power of two so the index wraps by masking.
    localparam int MEM_WORDS = 262144;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int IDX_W     = 18;

    localparam logic [6:0] OP_ALU   = 7'h33;
    localparam logic [6:0] OP_ALUI  = 7'h13;
    localparam logic [6:0] OP_LUI   = 7'h37;
    localparam logic [6:0] OP_LOAD  = 7'h03;
    localparam logic [6:0] OP_STORE = 7'h23;
    localparam logic [6:0] OP_JALR  = 7'h67;
    localparam logic [6:0] OP_SYS   = 7'h73;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_BYTEU = 3'd4;
    localparam logic [2:0] F3_JALR = 3'd0;

    localparam logic [XLEN-1:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [XLEN-1:0] LUI_MASK    = 32'hFFFF_F000;

    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_A0   = 5'd10;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_MEM
    } state_t;

    typedef struct packed {
        logic add;
        logic addi;
        logic lui;
        logic lw;
        logic lbu;
        logic sw;
        logic sb;
        logic jalr;
        logic ebreak;
    } dec_t;

    function automatic dec_t rvc_decode(input logic [XLEN-1:0] inst);
        dec_t       d;
        logic [6:0] op;
        logic [2:0] f3;
        op       = inst[6:0];
        f3       = inst[14:12];
        d.add    = (op == OP_ALU) && (f3 == F3_ADD) && (inst[31:25] == 7'd0);
        d.addi   = (op == OP_ALUI) && (f3 == F3_ADD);
        d.lui    = (op == OP_LUI);
        d.lw     = (op == OP_LOAD) && (f3 == F3_WORD);
        d.lbu    = (op == OP_LOAD) && (f3 == F3_BYTEU);
        d.sw     = (op == OP_STORE) && (f3 == F3_WORD);
        d.sb     = (op == OP_STORE) && (f3 == F3_BYTE);
        d.jalr   = (op == OP_JALR) && (f3 == F3_JALR);
        d.ebreak = (inst == EBREAK_WORD);
        return d;
    endfunction

endpackage

### rtl/core/rvc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rv32_subset_cpu_core.sv
// RV32 subset core: main memory, register file copies, sequencer and result register.
// Depends on rvc_pkg and rvc_ram.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_stall | kind, load_index, load_data
//   out     | out_valid/out_stall | pc_executed, instruction, dest_reg, dest_value,
//           |                     | halted, trap_good
//
// A load item is written to main memory from the idle state; a step runs fetch read,
// register read and execute, plus a data read for lw, lbu, sw and sb on the single
// main memory read port. A one-item input buffer takes the next item while one is at work.
// After reset a clearing pass zeroes every word of main memory and the register file,
// with in_stall high. A stalled result holds the core in its execute or memory state.
module rv32_subset_cpu_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic [rvc_pkg::IDX_W-1:0] load_index,
    input  logic [31:0]              load_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [31:0]              pc_executed,
    output logic [31:0]              instruction,
    output logic [4:0]               dest_reg,
    output logic [31:0]              dest_value,
    output logic                     halted,
    output logic                     trap_good
);
    import rvc_pkg::*;

    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);

    state_t state_reg, state_next;
    logic [MEM_AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic             pend_valid_reg, pend_valid_next;
    logic             pend_kind_reg;
    logic [IDX_W-1:0] pend_index_reg;
    logic [XLEN-1:0]  pend_data_reg;

    logic [XLEN-1:0] pc_reg, pc_next;
    logic            halt_reg, halt_next;
    logic [XLEN-1:0] a0_reg, a0_next;
    logic [XLEN-1:0] inst_reg, inst_next;
    logic [XLEN-1:0] addr_reg, addr_next;
    logic [XLEN-1:0] rs2v_reg, rs2v_next;

    logic              out_valid_reg, out_valid_next;
    logic [XLEN-1:0]   pc_out_reg, inst_out_reg, value_out_reg;
    logic [REG_AW-1:0] rd_out_reg;
    logic              halted_out_reg, trap_out_reg;

    logic            load_out;
    logic [XLEN-1:0] res_value;
    logic            res_halted, res_trap;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [XLEN-1:0]   mem_wdata, mem_rdata;

    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr, rfa_raddr, rfb_raddr;
    logic [XLEN-1:0]   rf_wdata, rfa_rdata, rfb_rdata;

    dec_t              dec_f, dec_x;
    logic [REG_AW-1:0] rs1_x, rs2_x, rd_x, sel_x;
    logic              mem_op_x, writes_x, needs_rs2_f, needs_rs2_x;
    logic [XLEN-1:0]   imm_i, imm_s, ea, alu_x, pc_plus4;
    logic [4:0]        sh_bits;
    logic [XLEN-1:0]   byte_mask, merged, load_val;
    logic              accept, take, out_free;

    rvc_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_main_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rvc_ram #(.WIDTH(XLEN), .DEPTH(REG_WORDS)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rfa_raddr),
        .rdata (rfa_rdata)
    );

    rvc_ram #(.WIDTH(XLEN), .DEPTH(REG_WORDS)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rfb_raddr),
        .rdata (rfb_rdata)
    );

    assign in_stall = (state_reg == ST_CLEAR) || (pend_valid_reg && (state_reg != ST_IDLE));
    assign accept   = in_valid && !in_stall;
    assign take     = pend_valid_reg && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign dec_f       = rvc_decode(mem_rdata);
    assign dec_x       = rvc_decode(inst_reg);
    assign needs_rs2_f = dec_f.add || dec_f.sw || dec_f.sb;
    assign needs_rs2_x = dec_x.add || dec_x.sw || dec_x.sb;
    assign mem_op_x    = dec_x.lw || dec_x.lbu || dec_x.sw || dec_x.sb;
    assign writes_x    = dec_x.add || dec_x.addi || dec_x.lui || dec_x.jalr;

    assign rs1_x = inst_reg[19:15];
    assign rs2_x = inst_reg[24:20];
    assign rd_x  = inst_reg[11:7];
    assign sel_x = (!halt_reg && needs_rs2_x) ? rs2_x : rd_x;

    assign imm_i    = {{20{inst_reg[31]}}, inst_reg[31:20]};
    assign imm_s    = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
    assign ea       = rfa_rdata + ((inst_reg[6:0] == OP_STORE) ? imm_s : imm_i);
    assign pc_plus4 = pc_reg + 32'd4;

    always_comb
    begin
        alu_x = pc_plus4;
        if (dec_x.add)
        begin
            alu_x = rfa_rdata + rfb_rdata;
        end
        else if (dec_x.addi)
        begin
            alu_x = ea;
        end
        else if (dec_x.lui)
        begin
            alu_x = inst_reg & LUI_MASK;
        end
    end

    assign sh_bits   = {addr_reg[1:0], 3'b000};
    assign byte_mask = 32'h0000_00FF << sh_bits;
    assign merged    = (mem_rdata & ~byte_mask) | ({24'd0, rs2v_reg[7:0]} << sh_bits);
    assign load_val  = dec_x.lw ? mem_rdata : ((mem_rdata >> sh_bits) & 32'h0000_00FF);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pc_next      = pc_reg;
        halt_next    = halt_reg;
        a0_next      = a0_reg;
        inst_next    = inst_reg;
        addr_next    = addr_reg;
        rs2v_next    = rs2v_reg;
        load_out     = 1'b0;
        res_value    = rfb_rdata;
        res_halted   = 1'b0;
        res_trap     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg[MEM_AW+1:2];
        mem_wdata    = rs2v_reg;
        mem_raddr    = pc_reg[MEM_AW+1:2];
        rf_we        = 1'b0;
        rf_waddr     = rd_x;
        rf_wdata     = alu_x;
        rfa_raddr    = rs1_x;
        rfb_raddr    = sel_x;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                rf_we        = 1'b1;
                rf_waddr     = clr_cnt_reg[REG_AW-1:0];
                rf_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pend_valid_reg)
                begin
                    if (pend_kind_reg == KIND_LOAD)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_index_reg[MEM_AW-1:0];
                        mem_wdata = pend_data_reg;
                    end
                    else
                    begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                inst_next  = mem_rdata;
                rfa_raddr  = mem_rdata[19:15];
                rfb_raddr  = (!halt_reg && needs_rs2_f) ? mem_rdata[24:20] : mem_rdata[11:7];
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                mem_raddr = ea[MEM_AW+1:2];
                addr_next = ea;
                rs2v_next = rfb_rdata;
                if (!halt_reg && mem_op_x)
                begin
                    rfb_raddr  = rd_x;
                    state_next = ST_MEM;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (halt_reg)
                    begin
                        res_halted = 1'b1;
                        res_trap   = (a0_reg == '0);
                    end
                    else
                    begin
                        if (writes_x)
                        begin
                            rf_we     = (rd_x != REG_ZERO);
                            res_value = (rd_x == REG_ZERO) ? '0 : alu_x;
                            if (rd_x == REG_A0)
                            begin
                                a0_next = alu_x;
                            end
                        end
                        halt_next  = dec_x.ebreak;
                        res_halted = dec_x.ebreak;
                        res_trap   = dec_x.ebreak && (a0_reg == '0);
                        if (dec_x.jalr)
                        begin
                            pc_next = ea & ~32'd1;
                        end
                        else if (!dec_x.ebreak)
                        begin
                            pc_next = pc_plus4;
                        end
                    end
                end
            end
            ST_MEM:
            begin
                rfb_raddr = rd_x;
                mem_raddr = addr_reg[MEM_AW+1:2];
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    pc_next    = pc_plus4;
                    if (dec_x.lw || dec_x.lbu)
                    begin
                        rf_we     = (rd_x != REG_ZERO);
                        rf_wdata  = load_val;
                        res_value = (rd_x == REG_ZERO) ? '0 : load_val;
                        if (rd_x == REG_A0)
                        begin
                            a0_next = load_val;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = dec_x.sw ? rs2v_reg : merged;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (take)
        begin
            pend_valid_next = 1'b0;
        end
    end

    assign out_valid_next = load_out ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            a0_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            pc_reg         <= pc_next;
            halt_reg       <= halt_next;
            a0_reg         <= a0_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_kind_reg  <= kind;
            pend_index_reg <= load_index;
            pend_data_reg  <= load_data;
        end
        inst_reg <= inst_next;
        addr_reg <= addr_next;
        rs2v_reg <= rs2v_next;
        if (load_out)
        begin
            pc_out_reg     <= pc_reg;
            inst_out_reg   <= inst_reg;
            rd_out_reg     <= rd_x;
            value_out_reg  <= res_value;
            halted_out_reg <= res_halted;
            trap_out_reg   <= res_trap;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pc_executed = pc_out_reg;
    assign instruction = inst_out_reg;
    assign dest_reg    = rd_out_reg;
    assign dest_value  = value_out_reg;
    assign halted      = halted_out_reg;
    assign trap_good   = trap_out_reg;

endmodule

### rtl/core/rvc_checker.sv
// Port-level checks for the RV32 subset core, bound to the top level.
// Depends on rvc_pkg and rv32_subset_cpu_core.
module rvc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      kind,
    input logic [rvc_pkg::IDX_W-1:0] load_index,
    input logic [31:0]               load_data,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [31:0]               pc_executed,
    input logic [31:0]               instruction,
    input logic [4:0]                dest_reg,
    input logic [31:0]               dest_value,
    input logic                      halted,
    input logic                      trap_good
);
    import rvc_pkg::*;

    logic        seen_halt_reg;
    logic [31:0] halt_pc_reg;
    logic        in_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
            halt_pc_reg   <= '0;
            in_seen_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_seen_reg <= in_seen_reg ^ kind ^ load_index[0] ^ load_data[0];
            end
            if (out_valid && !out_stall && halted && !seen_halt_reg)
            begin
                seen_halt_reg <= 1'b1;
                halt_pc_reg   <= pc_executed;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pc_executed)
            && $stable(instruction) && $stable(dest_value) && $stable(halted))
        else $error("stalled result changed");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_halt_reg |-> halted && (pc_executed == halt_pc_reg))
        else $error("result after halt not halted at frozen pc");

    a_ebreak_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (instruction == EBREAK_WORD) |-> halted)
        else $error("ebreak result without halt");

    a_trap_needs_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trap_good |-> halted)
        else $error("trap_good without halt");

    a_x0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (dest_reg == REG_ZERO) && (in_seen_reg || !in_seen_reg)
            |-> (dest_value == '0))
        else $error("x0 reads nonzero");

endmodule

bind rv32_subset_cpu_core rvc_checker u_rvc_checker (.*);

### bench/rv32_subset_cpu_core_tb.sv
// Self-checking bench for rv32_subset_cpu_core: loads programs into memory, steps them
// and checks every retired step against an architectural shadow of the core.
// Depends on rvc_pkg and the core RTL.
module rv32_subset_cpu_core_tb;

    import rvc_pkg::*;

    localparam int RANDOM_ITEMS = 1440;
    localparam int STALL_LIMIT  = 4 * MEM_WORDS + 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [XLEN-1:0]   data;
    } core_item_t;

    typedef struct packed {
        logic [XLEN-1:0]   pc;
        logic [XLEN-1:0]   inst;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   rd_val;
        logic              halt;
        logic              good;
    } retire_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              kind = KIND_LOAD;
    logic [IDX_W-1:0]  load_index = '0;
    logic [XLEN-1:0]   load_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [XLEN-1:0]   pc_executed;
    logic [XLEN-1:0]   instruction;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   dest_value;
    logic              halted;
    logic              trap_good;

    logic [XLEN-1:0]   shadow_mem [MEM_WORDS];
    logic [XLEN-1:0]   shadow_regs [REG_WORDS];
    logic [XLEN-1:0]   shadow_pc;
    logic              shadow_halt;

    core_item_t        pend_q [$];
    retire_t           retire_q [$];

    int                items_queued = 0;
    int                items_sent = 0;
    int                items_taken = 0;
    int                results_taken = 0;
    int                results_seen = 0;
    int                bad_results = 0;
    int                idle_cycles = 0;
    int                tx_wait = 0;
    int                rx_wait = 0;
    logic              tx_busy;
    logic              tx_burst = 1'b0;
    logic              rx_burst = 1'b0;
    logic              hold_done = 1'b0;
    logic              moved;
    core_item_t        next_item;
    retire_t           got;
    retire_t           want;

    rv32_subset_cpu_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .load_index  (load_index),
        .load_data   (load_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pc_executed (pc_executed),
        .instruction (instruction),
        .dest_reg    (dest_reg),
        .dest_value  (dest_value),
        .halted      (halted),
        .trap_good   (trap_good)
    );

    always #5 clk = ~clk;

    function automatic logic [XLEN-1:0] sext12(input logic [11:0] raw);
        return {{20{raw[11]}}, raw};
    endfunction

    function automatic void write_reg(input logic [REG_AW-1:0] rd, input logic [XLEN-1:0] v);
        if (rd != REG_ZERO)
        begin
            shadow_regs[rd] = v;
        end
    endfunction

    task automatic model_retire(input logic k, input logic [IDX_W-1:0] idx,
                                input logic [XLEN-1:0] data);
        logic [XLEN-1:0]   pc_now;
        logic [XLEN-1:0]   inst;
        logic [XLEN-1:0]   rs1v;
        logic [XLEN-1:0]   rs2v;
        logic [XLEN-1:0]   nxt;
        logic [XLEN-1:0]   addr;
        logic [XLEN-1:0]   imm;
        logic [REG_AW-1:0] rd;
        logic [2:0]        f3;
        logic [MEM_AW-1:0] slot;
        logic [4:0]        sh;
        retire_t           r;
        if (k == KIND_LOAD)
        begin
            shadow_mem[idx[MEM_AW-1:0]] = data;
        end
        else
        begin
            pc_now = shadow_pc;
            inst   = shadow_mem[pc_now[MEM_AW+1:2]];
            rd     = inst[11:7];
            if (!shadow_halt)
            begin
                f3   = inst[14:12];
                rs1v = shadow_regs[inst[19:15]];
                rs2v = shadow_regs[inst[24:20]];
                imm  = sext12(inst[31:20]);
                nxt  = pc_now + 32'd4;
                case (inst[6:0])
                    OP_ALU:
                    begin
                        if (f3 == F3_ADD && inst[31:25] == 7'd0)
                        begin
                            write_reg(rd, rs1v + rs2v);
                        end
                    end
                    OP_ALUI:
                    begin
                        if (f3 == F3_ADD)
                        begin
                            write_reg(rd, rs1v + imm);
                        end
                    end
                    OP_LUI:
                    begin
                        write_reg(rd, inst & LUI_MASK);
                    end
                    OP_LOAD:
                    begin
                        addr = rs1v + imm;
                        slot = addr[MEM_AW+1:2];
                        sh   = {addr[1:0], 3'b000};
                        if (f3 == F3_WORD)
                        begin
                            write_reg(rd, shadow_mem[slot]);
                        end
                        else if (f3 == F3_BYTEU)
                        begin
                            write_reg(rd, (shadow_mem[slot] >> sh) & 32'hFF);
                        end
                    end
                    OP_STORE:
                    begin
                        addr = rs1v + sext12({inst[31:25], inst[11:7]});
                        slot = addr[MEM_AW+1:2];
                        sh   = {addr[1:0], 3'b000};
                        if (f3 == F3_WORD)
                        begin
                            shadow_mem[slot] = rs2v;
                        end
                        else if (f3 == F3_BYTE)
                        begin
                            shadow_mem[slot] = (shadow_mem[slot] & ~(32'hFF << sh))
                                               | ({24'd0, rs2v[7:0]} << sh);
                        end
                    end
                    OP_JALR:
                    begin
                        if (f3 == F3_JALR)
                        begin
                            nxt = (rs1v + imm) & ~32'd1;
                            write_reg(rd, pc_now + 32'd4);
                        end
                    end
                    OP_SYS:
                    begin
                        if (inst == EBREAK_WORD)
                        begin
                            shadow_halt = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (!shadow_halt)
                begin
                    shadow_pc = nxt;
                end
            end
            r.pc     = pc_now;
            r.inst   = inst;
            r.rd     = rd;
            r.rd_val = shadow_regs[rd];
            r.halt   = shadow_halt;
            r.good   = shadow_halt && (shadow_regs[REG_A0] == '0);
            retire_q.push_back(r);
        end
    endtask

    function automatic logic [XLEN-1:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [2:0] f3,
                                              input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [XLEN-1:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                              input logic [2:0] f3, input logic [4:0] rd,
                                              input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [XLEN-1:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [2:0] f3,
                                              input logic [6:0] op);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
    endfunction

    function automatic logic [XLEN-1:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                              input logic [6:0] op);
        return {imm, rd, op};
    endfunction

    function automatic logic [XLEN-1:0] rand_word();
        logic [XLEN-1:0] w;
        w = $urandom;
        if (w == EBREAK_WORD)
        begin
            w = w ^ 32'h0010_0000;
        end
        return w;
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 1) == 0)
        begin
            return 5'($urandom_range(0, 3));
        end
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [11:0] pick_imm();
        logic [11:0] v;
        case ($urandom_range(0, 3))
            0: v = 12'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 12'h000;
                    1: v = 12'h7FF;
                    2: v = 12'h800;
                    default: v = 12'hFFF;
                endcase
            end
            default: v = 12'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic logic [XLEN-1:0] rand_inst();
        logic [4:0]      rd;
        logic [4:0]      rs1;
        logic [4:0]      rs2;
        logic [4:0]      mrs1;
        logic [11:0]     imm;
        logic [11:0]     mimm;
        logic [2:0]      f3;
        logic [XLEN-1:0] w;
        rd  = pick_reg();
        rs1 = pick_reg();
        rs2 = pick_reg();
        imm = pick_imm();
        // aim half of the memory ops and jumps at the low data window
        if ($urandom_range(0, 1) == 0)
        begin
            mrs1 = REG_ZERO;
            mimm = 12'($urandom_range(0, 255));
        end
        else
        begin
            mrs1 = rs1;
            mimm = imm;
        end
        f3 = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 15))
            0, 1: w = enc_r(7'd0, rs2, rs1, F3_ADD, rd, OP_ALU);
            2: w = enc_r(7'($urandom_range(1, 127)), rs2, rs1, f3, rd, OP_ALU);
            3, 4: w = enc_i(imm, rs1, F3_ADD, rd, OP_ALUI);
            5: w = enc_i(imm, rs1, 3'($urandom_range(1, 7)), rd, OP_ALUI);
            6: w = enc_u(20'($urandom), rd, OP_LUI);
            7: w = enc_i(mimm, mrs1, F3_WORD, rd, OP_LOAD);
            8: w = enc_i(mimm, mrs1, F3_BYTEU, rd, OP_LOAD);
            9:
            begin
                if (f3 == F3_WORD || f3 == F3_BYTEU)
                begin
                    f3 = 3'd1;
                end
                w = enc_i(mimm, mrs1, f3, rd, OP_LOAD);
            end
            10: w = enc_s(mimm, rs2, mrs1, F3_WORD, OP_STORE);
            11: w = enc_s(mimm, rs2, mrs1, F3_BYTE, OP_STORE);
            12:
            begin
                if (f3 == F3_WORD || f3 == F3_BYTE)
                begin
                    f3 = 3'd1;
                end
                w = enc_s(mimm, rs2, mrs1, f3, OP_STORE);
            end
            13: w = enc_i(mimm, mrs1, F3_JALR, rd, OP_JALR);
            14:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    w = enc_i(imm, rs1, 3'($urandom_range(1, 7)), rd, OP_JALR);
                end
                else
                begin
                    w = {25'($urandom), OP_SYS};
                end
            end
            default: w = $urandom;
        endcase
        if (w == EBREAK_WORD)
        begin
            w = w ^ 32'h0010_0000;
        end
        return w;
    endfunction

    task automatic push_item(input logic k, input logic [IDX_W-1:0] idx,
                             input logic [XLEN-1:0] data);
        core_item_t it;
        it.kind = k;
        it.idx  = idx;
        it.data = data;
        pend_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_step();
        push_item(KIND_STEP, IDX_W'($urandom), rand_word());
    endtask

    // sender: one item on the bus at a time, random gap after each accepted item
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            tx_busy = in_valid && (items_taken != items_sent);
            if (!tx_busy)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                end
                else if (pend_q.size() > 0)
                begin
                    next_item = pend_q.pop_front();
                    kind       <= next_item.kind;
                    load_index <= next_item.idx;
                    load_data  <= next_item.data;
                    items_sent++;
                    tx_busy = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                    begin
                        tx_burst = ~tx_burst;
                    end
                    tx_wait = tx_burst ? 0 : $urandom_range(0, 6);
                end
            end
            in_valid <= tx_busy;
        end
    end

    // receiver: random stall before each result, plus one long hold to back up the input
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_taken != results_seen)
            begin
                results_seen = results_taken;
                if ($urandom_range(0, 39) == 0)
                begin
                    rx_burst = ~rx_burst;
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
            end
            if (!hold_done && results_taken >= 200 && pend_q.size() >= 4
                && pend_q[pend_q.size() - 1].kind == KIND_STEP)
            begin
                rx_wait   = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            out_stall <= (rx_wait > 0);
            if (rx_wait > 0)
            begin
                rx_wait--;
            end
        end
    end

    always @(posedge clk)
    begin
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                results_taken++;
                got = {pc_executed, instruction, dest_reg, dest_value, halted, trap_good};
                if (retire_q.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                    begin
                        $display("unexpected result: pc=%h inst=%h rd=%0d val=%h halt=%b good=%b",
                                 got.pc, got.inst, got.rd, got.rd_val, got.halt, got.good);
                    end
                end
                else
                begin
                    want = retire_q.pop_front();
                    if (got !== want)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                        begin
                            $display("result %0d exp: pc=%h inst=%h rd=%0d val=%h halt=%b good=%b",
                                     results_taken, want.pc, want.inst, want.rd, want.rd_val,
                                     want.halt, want.good);
                            $display("result %0d act: pc=%h inst=%h rd=%0d val=%h halt=%b good=%b",
                                     results_taken, got.pc, got.inst, got.rd, got.rd_val,
                                     got.halt, got.good);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                items_taken++;
                model_retire(kind, load_index, load_data);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [MEM_AW-1:0] base;
        int                n;
        for (int i = 0; i < MEM_WORDS; i++)
        begin
            shadow_mem[i] = '0;
        end
        for (int i = 0; i < REG_WORDS; i++)
        begin
            shadow_regs[i] = '0;
        end
        shadow_pc   = '0;
        shadow_halt = 1'b0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed program at word 0, then a jump that wraps to the last word
        push_item(KIND_LOAD, IDX_W'(0), enc_u(20'hFFFFF, 5'd1, OP_LUI));
        push_item(KIND_LOAD, IDX_W'(1), enc_i(12'hFFF, REG_ZERO, F3_ADD, 5'd2, OP_ALUI));
        push_item(KIND_LOAD, IDX_W'(2), enc_r(7'd0, 5'd2, 5'd1, F3_ADD, 5'd3, OP_ALU));
        push_item(KIND_LOAD, IDX_W'(3), enc_s(12'h040, 5'd3, REG_ZERO, F3_WORD, OP_STORE));
        push_item(KIND_LOAD, IDX_W'(4), enc_s(12'h042, REG_ZERO, REG_ZERO, F3_BYTE, OP_STORE));
        push_item(KIND_LOAD, IDX_W'(5), enc_i(12'h043, REG_ZERO, F3_WORD, 5'd4, OP_LOAD));
        push_item(KIND_LOAD, IDX_W'(6), enc_i(12'h041, REG_ZERO, F3_BYTEU, 5'd5, OP_LOAD));
        push_item(KIND_LOAD, IDX_W'(7), enc_i(12'h005, 5'd2, F3_ADD, REG_ZERO, OP_ALUI));
        push_item(KIND_LOAD, IDX_W'(8), enc_i(12'h7FF, REG_ZERO, F3_ADD, 5'd6, OP_ALUI));
        push_item(KIND_LOAD, IDX_W'(9), enc_i(12'h000, 5'd2, F3_JALR, 5'd2, OP_JALR));
        push_item(KIND_LOAD, 18'h3FFFF, 32'hFFFF_FFFF);
        push_item(KIND_LOAD, IDX_W'(100), 32'h0000_0000);
        repeat (12) push_step();

        while (items_queued < RANDOM_ITEMS)
        begin
            wait (items_taken == items_queued);
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        push_item(1'($urandom), IDX_W'($urandom), $urandom);
                    end
                end
                1:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        push_item(KIND_LOAD, IDX_W'($urandom_range(0, 63)), rand_word());
                    end
                end
                default:
                begin
                    base = shadow_pc[MEM_AW+1:2];
                    n    = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                    begin
                        push_item(KIND_LOAD, IDX_W'(base + MEM_AW'(i)), rand_inst());
                    end
                    repeat (n + $urandom_range(0, 2)) push_step();
                end
            endcase
        end

        // halt with a0 clear, then step, load and step again while halted
        wait (items_taken == items_queued);
        base = shadow_pc[MEM_AW+1:2];
        push_item(KIND_LOAD, IDX_W'(base),
                  enc_i(12'h000, REG_ZERO, F3_ADD, REG_A0, OP_ALUI));
        push_item(KIND_LOAD, IDX_W'(base + 1'b1), EBREAK_WORD);
        repeat (5) push_step();
        push_item(KIND_LOAD, IDX_W'(base + 1'b1), rand_inst());
        repeat (2) push_step();
        push_item(KIND_LOAD, IDX_W'($urandom), rand_word());
        push_step();

        wait (items_taken == items_queued && retire_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_results == 0 && retire_q.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/rvc_pkg.sv
rtl/core/rvc_ram.sv
rtl/core/rv32_subset_cpu_core.sv
rtl/core/rvc_checker.sv
bench/rv32_subset_cpu_core_tb.sv
